@@ hdl/mwg_pkg.sv @@
// shared types, register codes and constants of the multi-waveform generator
// no dependencies; imported by every module of the block
package mwg_pkg;

    // default sizes handed down from the top level
    localparam int MWG_PHASE_BITS       = 32;
    localparam int MWG_SINE_TABLE_DEPTH = 1024;
    localparam int MWG_DUTY_BITS        = 16;

    // depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_WAVE_SELECT = 2'd0;
    localparam logic [1:0] CFG_PEAK_DUTY   = 2'd1;
    localparam logic [1:0] CFG_PHASE_STEP  = 2'd2;
    localparam logic [1:0] CFG_NOISE_SEED  = 2'd3;

    // wave_select codes
    localparam logic [2:0] WAVE_RAMP     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SINE     = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    // noise generator: right-shifting galois lfsr
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] LFSR_RESET = 16'h0001;

    // fixed-point sine table construction, Q30
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // shape class decided by the front for each word
    typedef enum logic [2:0] {
        SHAPE_RAMP,
        SHAPE_TRIANGLE,
        SHAPE_SINE,
        SHAPE_SQUARE,
        SHAPE_NOISE,
        SHAPE_NONE
    } shape_t;

    // configuration register file
    typedef struct packed {
        logic [2:0]  wave_select;
        logic [15:0] peak_duty;
        logic [31:0] phase_step;
        logic [15:0] noise_seed;
    } cfg_t;

    // sin(x) for 0 <= x <= pi/2 in Q30 by a nine-term series
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return (sum > ONE_Q30) ? ONE_Q30 : sum;
    endfunction

endpackage

@@ hdl/mwg_front.sv @@
// front of the generator: accepts sample words, advances phase and noise lfsr,
// classifies the waveform and pushes one entry per word into the queue; uses mwg_pkg
module mwg_front #(
    parameter int PHASE_BITS = mwg_pkg::MWG_PHASE_BITS,
    parameter int ENTRY_W    = PHASE_BITS + 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mwg_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    input  logic                 queue_full,
    output logic                 push,
    output logic [ENTRY_W-1:0]   push_data
);
    import mwg_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [15:0]           lfsr_reg;
    logic [15:0]           lfsr_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [15:0]           lfsr_cur;
    logic [15:0]           seed;
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS:0]   sum;
    shape_t                shape;

    // accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // restart clears the phase and reloads a nonzero seed
    assign seed      = (cfg.noise_seed == 16'd0) ? LFSR_RESET : cfg.noise_seed;
    assign phase_cur = restart ? '0 : phase_reg;
    assign lfsr_cur  = restart ? seed : lfsr_reg;

    // phase advance, carry out marks the last sample of the period
    assign step = PHASE_BITS'(cfg.phase_step);
    assign sum  = {1'b0, phase_cur} + {1'b0, step};
    assign phase_next = sum[PHASE_BITS-1:0];

    // one galois step after every sample
    assign lfsr_next = lfsr_cur[0] ? ((lfsr_cur >> 1) ^ LFSR_TAPS) : (lfsr_cur >> 1);

    // waveform class
    always_comb
    begin
        unique case (cfg.wave_select)
            WAVE_RAMP:     shape = SHAPE_RAMP;
            WAVE_TRIANGLE: shape = SHAPE_TRIANGLE;
            WAVE_SINE:     shape = SHAPE_SINE;
            WAVE_SQUARE:   shape = SHAPE_SQUARE;
            WAVE_NOISE:    shape = SHAPE_NOISE;
            default:       shape = SHAPE_NONE;
        endcase
    end

    assign push_data = {shape, sum[PHASE_BITS], lfsr_cur, phase_cur};

    // generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lfsr_reg  <= LFSR_RESET;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
        end
    end

endmodule

@@ hdl/mwg_queue.sv @@
// short show-ahead queue between the front and the back
// depth from mwg_pkg, entry width from the instantiating module
module mwg_queue #(
    parameter int WIDTH = mwg_pkg::MWG_PHASE_BITS + 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    import mwg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == DEPTH_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // fill count stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    // a lone push grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not update count");

endmodule

@@ hdl/mwg_back.sv @@
// back of the generator: sine rom read, one multiply by peak duty, scaling,
// and the output register; uses mwg_pkg for shape codes and table math
module mwg_back #(
    parameter int PHASE_BITS       = mwg_pkg::MWG_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = mwg_pkg::MWG_SINE_TABLE_DEPTH,
    parameter int DUTY_BITS        = mwg_pkg::MWG_DUTY_BITS,
    parameter int ENTRY_W          = PHASE_BITS + 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mwg_pkg::cfg_t        cfg,
    input  logic                 queue_valid,
    input  logic [ENTRY_W-1:0]   queue_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          duty,
    output logic                 period_end
);
    import mwg_pkg::*;

    localparam int IW  = $clog2(SINE_TABLE_DEPTH);
    localparam int SPW = PHASE_BITS - 2 + IW;
    localparam int NW  = PHASE_BITS + 1;
    localparam int PW  = DUTY_BITS + NW;
    localparam logic [63:0] ROM_DIV = 64'(4 * SINE_TABLE_DEPTH);
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [NW-1:0] FULL_TURN = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [IW-1:0] IDX_LAST = IW'(SINE_TABLE_DEPTH - 1);
    localparam logic [16:0] SINE_OFFSET = 17'h10000;

    // quarter-wave table entry k, sampled at angle (2k+1)*pi/(4*depth)
    function automatic logic [15:0] rom_entry(input int k);
        logic [63:0] x;
        logic [63:0] v;
        x = (64'(2 * k + 1) * PI_Q30) / ROM_DIV;
        v = (sin_q30(x) * 64'd65535 + (ONE_Q30 >> 1)) >> 30;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    logic [15:0] sine_rom [SINE_TABLE_DEPTH];

    // constant table contents
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_sine_rom
        assign sine_rom[k] = rom_entry(k);
    end

    // queue entry fields
    logic [PHASE_BITS-1:0] q_phase;
    logic [15:0]           q_lfsr;
    logic                  q_period_end;
    shape_t                q_shape;

    // stage 1: operand select and rom address
    logic [PHASE_BITS-3:0] ph_low;
    logic [SPW-1:0]        sine_prod;
    logic [IW-1:0]         sine_idx_raw;
    logic [IW-1:0]         sine_idx;
    logic [NW-1:0]         num_pre;
    logic [NW-1:0]         tri_fall;

    logic                  s1_valid_reg;
    shape_t                s1_shape_reg;
    logic                  s1_period_end_reg;
    logic                  s1_second_half_reg;
    logic [NW-1:0]         s1_num_reg;
    logic [15:0]           rom_q_reg;

    // stage 2: product
    logic [NW-1:0]         num;
    logic [DUTY_BITS-1:0]  peak;
    logic                  s2_valid_reg;
    shape_t                s2_shape_reg;
    logic                  s2_period_end_reg;
    logic [PW-1:0]         prod_reg;

    // output stage
    logic [PW-1:0]         scaled;
    logic                  out_valid_reg;
    logic [15:0]           duty_reg;
    logic                  period_end_reg;
    logic                  adv;

    assign q_phase      = queue_data[PHASE_BITS-1:0];
    assign q_lfsr       = queue_data[PHASE_BITS+15:PHASE_BITS];
    assign q_period_end = queue_data[PHASE_BITS+16];
    assign q_shape      = shape_t'(queue_data[PHASE_BITS+19:PHASE_BITS+17]);

    // whole pipeline moves unless a finished word waits at the output
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && queue_valid;

    // sine table index inside the quadrant, mirrored on odd quadrants
    assign ph_low       = q_phase[PHASE_BITS-3:0];
    assign sine_prod    = SPW'(ph_low) * SPW'(SINE_TABLE_DEPTH);
    assign sine_idx_raw = sine_prod[SPW-1 -: IW];
    assign sine_idx     = q_phase[PHASE_BITS-2] ? (IDX_LAST - sine_idx_raw) : sine_idx_raw;

    // triangle falling edge operand
    assign tri_fall = (FULL_TURN - NW'(q_phase)) << 1;

    // multiplicand per shape, ramp, triangle and square scaled by 2^phase_bits, noise by 2^16
    always_comb
    begin
        unique case (q_shape)
            SHAPE_RAMP:     num_pre = NW'(q_phase);
            SHAPE_TRIANGLE: num_pre = (q_phase <= HALF) ? (NW'(q_phase) << 1) : tri_fall;
            SHAPE_SQUARE:   num_pre = (q_phase <= HALF) ? FULL_TURN : '0;
            SHAPE_NOISE:    num_pre = NW'(q_lfsr);
            default:        num_pre = '0;
        endcase
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_shape_reg       <= q_shape;
            s1_period_end_reg  <= q_period_end;
            s1_second_half_reg <= q_phase[PHASE_BITS-1];
            s1_num_reg         <= num_pre;
            rom_q_reg          <= sine_rom[sine_idx];
        end
    end

    // sine multiplicand is one plus or minus the table entry
    assign num  = (s1_shape_reg == SHAPE_SINE)
                ? (s1_second_half_reg ? NW'(SINE_OFFSET - {1'b0, rom_q_reg})
                                      : NW'(SINE_OFFSET + {1'b0, rom_q_reg}))
                : s1_num_reg;
    assign peak = cfg.peak_duty[DUTY_BITS-1:0];

    // stage 2 registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_shape_reg      <= s1_shape_reg;
            s2_period_end_reg <= s1_period_end_reg;
            prod_reg          <= PW'(peak) * PW'(num);
        end
    end

    // scale back to duty counts
    always_comb
    begin
        case (s2_shape_reg)
            SHAPE_SINE:  scaled = prod_reg >> 17;
            SHAPE_NOISE: scaled = prod_reg >> 16;
            default:     scaled = prod_reg >> PHASE_BITS;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            duty_reg       <= 16'(scaled[DUTY_BITS-1:0]);
            period_end_reg <= s2_period_end_reg;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= queue_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty       = duty_reg;
    assign period_end = period_end_reg;

    // a word in stage 1 reaches stage 2 when the pipeline moves
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg) |=> s2_valid_reg)
        else $error("stage 1 word lost");

endmodule

@@ hdl/multi_waveform_generator.sv @@
// top level of the multi-waveform generator: configuration registers,
// front, queue and back; depends on mwg_pkg, mwg_front, mwg_queue, mwg_back
//
// Each accepted word is one sample tick and yields one word holding a PWM
// duty value and a period_end flag. A phase accumulator of PHASE_BITS bits
// advances by phase_step per sample; duty is peak_duty times the selected
// ramp, triangle, sine (quarter-wave ROM), square or noise (16-bit LFSR)
// shape. restart clears the phase and reloads the seed before its sample.
// One word is accepted per clock while the queue has room; the front updates
// phase and LFSR in the accept cycle, and a result passes through the queue,
// ROM read, multiply and output register, so a steady stream moves one word
// per cycle while out_ready stays high. The configuration port is always
// ready; registers are meant to be written while no sample is in flight.
module multi_waveform_generator #(
    parameter int PHASE_BITS       = mwg_pkg::MWG_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = mwg_pkg::MWG_SINE_TABLE_DEPTH,
    parameter int DUTY_BITS        = mwg_pkg::MWG_DUTY_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] duty,
    output logic        period_end
);
    import mwg_pkg::*;

    localparam int ENTRY_W = PHASE_BITS + 20;

    cfg_t               cfg_reg;
    logic               queue_full;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic               queue_valid;
    logic [ENTRY_W-1:0] queue_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_select <= WAVE_RAMP;
            cfg_reg.peak_duty   <= 16'd0;
            cfg_reg.phase_step  <= 32'd1;
            cfg_reg.noise_seed  <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WAVE_SELECT: cfg_reg.wave_select <= cfg_data[2:0];
                CFG_PEAK_DUTY:   cfg_reg.peak_duty   <= cfg_data[15:0];
                CFG_PHASE_STEP:  cfg_reg.phase_step  <= cfg_data;
                CFG_NOISE_SEED:  cfg_reg.noise_seed  <= cfg_data[15:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // phase, noise and shape class
    mwg_front #(
        .PHASE_BITS (PHASE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // decoupling queue
    mwg_queue #(
        .WIDTH      (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .valid      (queue_valid),
        .pop_data   (queue_data)
    );

    // duty computation and output register
    mwg_back #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .DUTY_BITS        (DUTY_BITS),
        .ENTRY_W          (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_valid (queue_valid),
        .queue_data  (queue_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty        (duty),
        .period_end  (period_end)
    );

endmodule

@@ verif/tb_multi_waveform_generator.sv @@
// self-checking testbench of multi_waveform_generator: a directed pass over
// every waveform and corner, then randomized settings with random idling;
// depends on mwg_pkg and the generator RTL only
module tb_multi_waveform_generator;

    import mwg_pkg::*;

    localparam int          SINE_DEPTH  = MWG_SINE_TABLE_DEPTH;
    localparam bit [63:0]   PHASE_FULL  = 64'h1_0000_0000;
    localparam bit [63:0]   PHASE_HALF  = 64'h0_8000_0000;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned REPORT_CAP  = 100;

    // wave_select codes with no waveform behind them
    localparam logic [2:0] WAVE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] WAVE_SPARE_LAST  = 3'd7;

    // idling schemes
    localparam int IDLE_SENDER_LIGHT = 0;
    localparam int IDLE_SENDER_HEAVY = 1;
    localparam int IDLE_NONE         = 2;

    typedef struct packed {
        logic [15:0] duty;
        logic        period_end;
    } sample_t;

    // dut ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WAVE_SELECT;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] duty;
    logic        period_end;

    // generator model: settings and running state
    logic [2:0]  sel_wave   = WAVE_RAMP;
    logic [15:0] peak_level = 16'd0;
    logic [31:0] phase_inc  = 32'd1;
    logic [15:0] seed_value = 16'd1;
    logic [31:0] phase_acc  = 32'd0;
    logic [15:0] lfsr_state = LFSR_RESET;
    bit   [15:0] quarter_sine [SINE_DEPTH];

    logic pending_restarts [$];
    sample_t expected_samples [$];

    int unsigned words_queued    = 0;
    int unsigned results_seen    = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned settings_count  = 0;
    int unsigned period_ends     = 0;
    int unsigned restarts_taken  = 0;
    bit   [7:0]  waves_seen      = 8'd0;
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;

    multi_waveform_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty       (duty),
        .period_end (period_end)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sin over 0..pi/2 in Q30, nine-term series with floor at zero
    function automatic bit [63:0] sine_q30(input bit [63:0] angle);
        bit [63:0] sq;
        bit [63:0] term;
        bit [63:0] acc;
        sq   = (angle * angle) >> 30;
        term = angle;
        acc  = angle;
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return (acc > (64'd1 << 30)) ? (64'd1 << 30) : acc;
    endfunction

    // quarter-wave table, sampled at bin centers
    task automatic fill_quarter_sine();
        bit [63:0] angle;
        bit [63:0] level;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            angle = (64'(2 * k + 1) * PI_Q30) / (64'd4 * 64'(SINE_DEPTH));
            level = (sine_q30(angle) * 64'd65535 + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (level > 64'd65535) ? 16'hFFFF : level[15:0];
        end
    endtask

    // register write as the block sees it
    function automatic void latch_reg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_WAVE_SELECT: sel_wave   = data[2:0];
            CFG_PEAK_DUTY:   peak_level = data[15:0];
            CFG_PHASE_STEP:  phase_inc  = data;
            CFG_NOISE_SEED:  seed_value = data[15:0];
            default: ;
        endcase
    endfunction

    // duty and period flag of one sample tick; advances phase and lfsr
    function automatic sample_t next_sample(input logic rs);
        sample_t   s;
        bit [63:0] ph;
        bit [63:0] pk;
        bit [63:0] num;
        bit [63:0] sum;
        bit [63:0] idx;
        bit [1:0]  quad;
        bit        lsb;
        if (rs)
        begin
            phase_acc  = 32'd0;
            lfsr_state = (seed_value != 16'd0) ? seed_value : LFSR_RESET;
        end
        ph = 64'(phase_acc);
        pk = 64'(peak_level);
        case (sel_wave)
            WAVE_RAMP:
                num = (pk * ph) >> 32;
            WAVE_TRIANGLE:
                num = (ph <= PHASE_HALF) ? (pk * (ph << 1)) >> 32
                                         : (pk * ((PHASE_FULL - ph) << 1)) >> 32;
            WAVE_SINE:
            begin
                quad = ph[31:30];
                idx  = (64'(ph[29:0]) * 64'(SINE_DEPTH)) >> 30;
                if (quad[0])
                begin
                    idx = 64'(SINE_DEPTH - 1) - idx;
                end
                num = (quad < 2'd2) ? 64'd65536 + 64'(quarter_sine[idx])
                                    : 64'd65536 - 64'(quarter_sine[idx]);
                num = (pk * num) >> 17;
            end
            WAVE_SQUARE:
                num = (ph <= PHASE_HALF) ? pk : 64'd0;
            WAVE_NOISE:
                num = (pk * 64'(lfsr_state)) >> 16;
            default:
                num = 64'd0;
        endcase
        s.duty = num[15:0];
        sum = ph + 64'(phase_inc);
        s.period_end = sum[32];
        phase_acc = sum[31:0];
        lsb = lfsr_state[0];
        lfsr_state = lfsr_state >> 1;
        if (lsb)
        begin
            lfsr_state = lfsr_state ^ LFSR_TAPS;
        end
        return s;
    endfunction

    // sender: feeds queued words, predicts each on acceptance
    always @(posedge clk or negedge rst_n)
    begin : word_sender
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(next_sample(restart));
                waves_seen[sel_wave] = 1'b1;
                if (restart)
                begin
                    restarts_taken++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (pending_restarts.size() != 0 &&
                    $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= pending_restarts.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    restart  <= 1'($urandom_range(1, 0));
                end
            end
        end
    end

    // receiver: random back-pressure and field checks
    always @(posedge clk or negedge rst_n)
    begin : sample_checker
        sample_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                    begin
                        $display("%0t: unexpected word, duty %h period_end %b",
                                 $time, duty, period_end);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (period_end)
                    begin
                        period_ends++;
                    end
                    if (duty !== want.duty)
                    begin
                        error_count++;
                        if (error_count <= REPORT_CAP)
                        begin
                            $display("%0t: duty expected %h got %h",
                                     $time, want.duty, duty);
                        end
                    end
                    if (period_end !== want.period_end)
                    begin
                        error_count++;
                        if (error_count <= REPORT_CAP)
                        begin
                            $display("%0t: period_end expected %b got %b",
                                     $time, want.period_end, period_end);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
        end
    end

    // run guard
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d of %0d words back",
                 cycle_count, results_seen, words_queued);
        $display("tb_multi_waveform_generator: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        latch_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // all four registers, only while nothing is in flight
    task automatic load_settings(input logic [31:0] wave_d, input logic [31:0] peak_d,
                                 input logic [31:0] step_d, input logic [31:0] seed_d);
        write_reg(CFG_WAVE_SELECT, wave_d);
        write_reg(CFG_PEAK_DUTY, peak_d);
        write_reg(CFG_PHASE_STEP, step_d);
        write_reg(CFG_NOISE_SEED, seed_d);
        settings_count++;
    endtask

    task automatic queue_word(input logic rs);
        pending_restarts.push_back(rs);
        words_queued++;
    endtask

    // stimulus waits until every queued word has come back
    task automatic drain_all();
        while (results_seen < words_queued)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void set_idling(input int scheme);
        case (scheme)
            IDLE_SENDER_LIGHT:
            begin
                sender_idle_pct   = 12;
                receiver_idle_pct = 52;
            end
            IDLE_SENDER_HEAVY:
            begin
                sender_idle_pct   = 52;
                receiver_idle_pct = 12;
            end
            default:
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endfunction

    // a short directed run: restart then a few plain ticks
    task automatic directed_run(input logic [2:0] wave, input logic [15:0] peak,
                                input logic [31:0] step, input logic [15:0] seed,
                                input int ticks);
        load_settings({29'd0, wave}, {16'd0, peak}, step, {16'd0, seed});
        queue_word(1'b1);
        for (int i = 1; i < ticks; i++)
        begin
            queue_word(1'b0);
        end
        drain_all();
    endtask

    // random settings and words for one stretch between register writes
    task automatic random_run();
        logic [2:0]  wave;
        logic [31:0] wave_d;
        logic [31:0] peak_d;
        logic [31:0] step_d;
        logic [31:0] seed_d;
        int          pick;
        int          ticks;
        wave = ($urandom_range(99, 0) < 92) ? 3'($urandom_range(4, 0))
                                            : 3'($urandom_range(WAVE_SPARE_LAST,
                                                                WAVE_SPARE_FIRST));
        wave_d = $urandom_range(1, 0) ? (($urandom & 32'hFFFF_FFF8) | 32'(wave))
                                      : 32'(wave);
        pick = $urandom_range(99, 0);
        peak_d = (pick < 10) ? 32'h0000_0000 :
                 (pick < 25) ? 32'h0000_FFFF : 32'($urandom_range(65535, 0));
        if ($urandom_range(1, 0))
        begin
            peak_d[31:16] = 16'($urandom);
        end
        pick = $urandom_range(99, 0);
        if (pick < 4)
        begin
            step_d = 32'd0;
        end
        else if (pick < 8)
        begin
            step_d = 32'hFFFF_FFFF;
        end
        else if (pick < 12)
        begin
            step_d = 32'($urandom_range(3, 1));
        end
        else if (pick < 70)
        begin
            // about 3 to 200 samples per period, so the whole shape is swept
            step_d = 32'hFFFF_FFFF / 32'($urandom_range(200, 3)) + 32'($urandom_range(255, 0));
        end
        else
        begin
            step_d = $urandom;
        end
        seed_d = ($urandom_range(99, 0) < 8) ? {16'($urandom_range(65535, 0)), 16'd0}
                                             : $urandom;
        load_settings(wave_d, peak_d, step_d, seed_d);
        ticks = $urandom_range(110, 20);
        for (int i = 0; i < ticks; i++)
        begin
            queue_word((i == 0 && $urandom_range(1, 0)) || $urandom_range(99, 0) < 4);
        end
        drain_all();
    endtask

    initial
    begin : stimulus
        int unsigned random_start;
        fill_quarter_sine();
        set_idling(IDLE_SENDER_LIGHT);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // two ticks on the reset settings
        queue_word(1'b0);
        queue_word(1'b0);
        drain_all();

        // ramp, triangle and sine at the quarter points with a wrap on the last tick; square at the half points
        directed_run(WAVE_RAMP, 16'hFFFF, 32'h4000_0000, 16'd1, 4);
        directed_run(WAVE_TRIANGLE, 16'hFFFF, 32'h4000_0000, 16'd1, 4);
        directed_run(WAVE_SINE, 16'hFFFF, 32'h4000_0000, 16'd1, 4);
        directed_run(WAVE_SQUARE, 16'hFFFF, 32'h8000_0000, 16'd1, 3);
        // zero seed falls back to one
        directed_run(WAVE_NOISE, 16'hFFFF, 32'h1234_5678, 16'd0, 3);
        // spare select code gives zero duty
        directed_run(WAVE_SPARE_LAST, 16'hFFFF, 32'h9000_0000, 16'hACE1, 2);
        // zero step holds the phase, max step wraps almost every tick
        directed_run(WAVE_RAMP, 16'h8001, 32'd0, 16'hFFFF, 2);
        directed_run(WAVE_TRIANGLE, 16'd0, 32'hFFFF_FFFF, 16'h0001, 3);

        // random part in three idling schemes
        random_start = words_queued;
        while (words_queued - random_start < RANDOM_WORDS)
        begin
            if (words_queued - random_start < RANDOM_WORDS / 3)
            begin
                set_idling(IDLE_SENDER_LIGHT);
            end
            else if (words_queued - random_start < 2 * RANDOM_WORDS / 3)
            begin
                set_idling(IDLE_SENDER_HEAVY);
            end
            else
            begin
                set_idling(IDLE_NONE);
            end
            random_run();
        end

        drain_all();
        repeat (10) @(posedge clk);
        $display("covered %0d samples over %0d register settings, waves seen %b",
                 results_seen, settings_count, waves_seen);
        $display("%0d restarts, %0d period ends, %0d failures",
                 restarts_taken, period_ends, error_count);
        if (error_count == 0)
        begin
            $display("tb_multi_waveform_generator: done, clean");
        end
        else
        begin
            $display("tb_multi_waveform_generator: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mwg_pkg.sv
hdl/mwg_front.sv
hdl/mwg_queue.sv
hdl/mwg_back.sv
hdl/multi_waveform_generator.sv
verif/tb_multi_waveform_generator.sv
